// ----- rtl/utf8seg_pkg.sv -----
// Package: shared types and byte-class constants for the UTF-8 character segmenter.
`default_nettype none
package utf8seg_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CHAR_W  = 32;
	localparam int unsigned PART_W  = 24;
	localparam int unsigned CNT_W   = 2;
	localparam int unsigned LEN_W   = 3;

	// Byte class masks and codes
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

	// Character lengths
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

	// Segmenter state carried between items
	typedef struct packed {
		logic [PART_W-1:0] gathered;    // partial character, first byte in 7:0
		logic [CNT_W-1:0]  count;       // bytes gathered so far
		logic [LEN_W-1:0]  expected;    // current char length, 0 = awaiting lead
		logic              discarding;  // dropping rest of a rejected text
	} seg_state_t;

	// One result item
	typedef struct packed {
		logic [CHAR_W-1:0] char_bytes;
		logic [LEN_W-1:0]  char_length;
		logic              malformed;
		logic              text_done;
	} seg_result_t;

endpackage
`default_nettype wire

// ----- rtl/utf8seg_decode.sv -----
// Combinational step: classify one byte against the current state.
`default_nettype none
module utf8seg_decode (
	input  wire utf8seg_pkg::seg_state_t              cur,
	input  wire logic [utf8seg_pkg::BYTE_W-1:0]       byte_in,
	input  wire logic                                 eot,
	output utf8seg_pkg::seg_state_t                   nxt,
	output logic                                      res_valid,
	output utf8seg_pkg::seg_result_t                  res
);

	logic [utf8seg_pkg::LEN_W-1:0]  lead_len;
	logic [utf8seg_pkg::CHAR_W-1:0] packed_bytes;
	logic [utf8seg_pkg::LEN_W-1:0]  next_count;
	logic                           is_cont;

	always_comb begin
		if ((byte_in & utf8seg_pkg::LEAD2_MASK) == utf8seg_pkg::LEAD2_CODE) begin
			lead_len = utf8seg_pkg::LEN_2;
		end else if ((byte_in & utf8seg_pkg::LEAD3_MASK) == utf8seg_pkg::LEAD3_CODE) begin
			lead_len = utf8seg_pkg::LEN_3;
		end else if ((byte_in & utf8seg_pkg::LEAD4_MASK) == utf8seg_pkg::LEAD4_CODE) begin
			lead_len = utf8seg_pkg::LEN_4;
		end else begin
			lead_len = utf8seg_pkg::LEN_NONE;
		end
	end

	assign is_cont    = (byte_in & utf8seg_pkg::CONT_MASK) == utf8seg_pkg::CONT_CODE;
	assign next_count = {1'b0, cur.count} + utf8seg_pkg::LEN_1;

	// Place the new byte at the slot given by the gathered count.
	always_comb begin
		packed_bytes = {8'h00, cur.gathered};
		case (cur.count)
			2'd0:    packed_bytes[7:0]   = packed_bytes[7:0]   | byte_in;
			2'd1:    packed_bytes[15:8]  = packed_bytes[15:8]  | byte_in;
			2'd2:    packed_bytes[23:16] = packed_bytes[23:16] | byte_in;
			default: packed_bytes[31:24] = packed_bytes[31:24] | byte_in;
		endcase
	end

	always_comb begin
		logic reject;
		reject    = 1'b0;
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		if (cur.discarding) begin
			if (eot) begin
				nxt.discarding = 1'b0;
			end
		end else if (cur.expected == utf8seg_pkg::LEN_NONE) begin
			if (!byte_in[7]) begin
				res_valid       = 1'b1;
				res.char_bytes  = {24'h000000, byte_in};
				res.char_length = utf8seg_pkg::LEN_1;
				res.text_done   = eot;
			end else if (lead_len == utf8seg_pkg::LEN_NONE || eot) begin
				reject = 1'b1;
			end else begin
				nxt.gathered = {16'h0000, byte_in};
				nxt.count    = 2'd1;
				nxt.expected = lead_len;
			end
		end else if (!is_cont) begin
			reject = 1'b1;
		end else if (next_count >= cur.expected) begin
			res_valid       = 1'b1;
			res.char_bytes  = packed_bytes;
			res.char_length = cur.expected;
			res.text_done   = eot;
			nxt             = '0;
		end else if (eot) begin
			reject = 1'b1;
		end else begin
			nxt.gathered = packed_bytes[utf8seg_pkg::PART_W-1:0];
			nxt.count    = next_count[utf8seg_pkg::CNT_W-1:0];
		end

		if (reject) begin
			nxt            = '0;
			nxt.discarding = !eot;
			res_valid      = 1'b1;
			res            = '0;
			res.malformed  = 1'b1;
			res.text_done  = 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/utf8seg_outreg.sv -----
// Result register: holds one result item until the consumer takes it.
`default_nettype none
module utf8seg_outreg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 load,
	input  wire utf8seg_pkg::seg_result_t             res_in,
	output logic                                      free,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output utf8seg_pkg::seg_result_t                  res_out
);

	logic                      valid_q;
	utf8seg_pkg::seg_result_t  res_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule
`default_nettype wire

// ----- rtl/utf8_character_segmenter.sv -----
// Top level: UTF-8 character segmenter with input register, step logic and result register.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid, in_ready, in_byte, end_of_text        | in
//   out     | out_valid, out_ready, char_bytes, char_length,  | out
//           | malformed, text_done                            |
//
// One byte per cycle sustained while results are taken; an accepted item is held in
// the input register, and its result (if any) is then held in the result register.
// The combinational step is the byte classifier and packer against the state regs.
// Reset clears the state, so the first byte after reset is taken as a lead.
// A held result stalls the input register; if that register is empty one more
// item is still taken while the result waits, then in_ready stays low until
// out_ready returns.
`default_nettype none
module utf8_character_segmenter (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [utf8seg_pkg::BYTE_W-1:0]       in_byte,
	input  wire logic                                 end_of_text,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [utf8seg_pkg::CHAR_W-1:0]            char_bytes,
	output logic [utf8seg_pkg::LEN_W-1:0]             char_length,
	output logic                                      malformed,
	output logic                                      text_done
);

	// Input register stage
	logic                              valid_s1;
	logic [utf8seg_pkg::BYTE_W-1:0]    byte_s1;
	logic                              eot_s1;

	// Segmenter state
	utf8seg_pkg::seg_state_t           state_q;
	utf8seg_pkg::seg_state_t           state_nxt;

	// Step results
	logic                              res_valid;
	utf8seg_pkg::seg_result_t          res;
	utf8seg_pkg::seg_result_t          res_out;
	logic                              out_free;
	logic                              step;

	// The stage in s1 moves on whenever the result register can take a new item;
	// an item with no result just passes through.
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eot_s1  <= end_of_text;
		end
	end

	// State advances once per item, in the cycle it leaves s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	utf8seg_decode u_decode (
		.cur       (state_q),
		.byte_in   (byte_s1),
		.eot       (eot_s1),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	utf8seg_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && res_valid),
		.res_in    (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign char_bytes  = res_out.char_bytes;
	assign char_length = res_out.char_length;
	assign malformed   = res_out.malformed;
	assign text_done   = res_out.text_done;

	// Error items carry no character and always close the text.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && malformed |-> char_length == utf8seg_pkg::LEN_NONE
			&& char_bytes == '0 && text_done)
		else $error("error item with character data or open text");

	// Good items carry a length of one to four.
	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !malformed |-> char_length != utf8seg_pkg::LEN_NONE
			&& char_length <= utf8seg_pkg::LEN_4)
		else $error("character item with bad length");

	// While discarding no partial character is held.
	a_discard_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.discarding |-> state_q.expected == utf8seg_pkg::LEN_NONE
			&& state_q.count == '0)
		else $error("partial character kept while discarding");

	// Gathered count stays below the expected length, and is zero awaiting a lead.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.expected == utf8seg_pkg::LEN_NONE && state_q.count == '0)
		|| ({1'b0, state_q.count} < state_q.expected && state_q.count != '0))
		else $error("gathered count out of range");

	// An item leaving s1 without a result never leaves a result behind.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		step && !res_valid |=> !out_valid)
		else $error("result item appeared without a source");

endmodule
`default_nettype wire
